>>> rtl/tvp_pkg.sv
// Shared types and constants of the trapezoidal velocity profile core.
`default_nettype none

package tvp_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOP_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL     = 2'd1;

  localparam logic [CFG_W-1:0] TOP_SPEED_RST = 16'd1024;
  localparam logic [CFG_W-1:0] ACCEL_RST     = 16'd1024;

  typedef enum logic [1:0] {
    PH_SHORT  = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DECEL  = 2'd3
  } tvp_phase_t;

  typedef struct packed {
    logic adv;
    logic vld;
  } tvp_flow_t;

endpackage

`default_nettype wire

>>> rtl/tvp_div2.sv
// Pipelined restoring divider: two numerators over one shared divisor, one bit per stage.
`default_nettype none

module tvp_div2 #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 17,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tvp_pkg::tvp_flow_t     flow_i,
  input  logic [NUM_W-1:0]       num0_i,
  input  logic [NUM_W-1:0]       num1_i,
  input  logic [DEN_W-1:0]       den_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   vld_o,
  output logic [NUM_W-1:0]       quo0_o,
  output logic [NUM_W-1:0]       quo1_o,
  output logic [SIDE_W-1:0]      side_o
);
  import tvp_pkg::*;

  logic [DEN_W-1:0]  rem0_r [NUM_W];
  logic [DEN_W-1:0]  rem1_r [NUM_W];
  logic [NUM_W-1:0]  nq0_r  [NUM_W];
  logic [NUM_W-1:0]  nq1_r  [NUM_W];
  logic [DEN_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];
  logic [NUM_W-1:0]  vld_r;

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W-1:0]  rem0_in, rem1_in, den_in;
    logic [NUM_W-1:0]  nq0_in, nq1_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [DEN_W:0]    t0, t1;
    logic              ge0, ge1;
    logic [DEN_W-1:0]  rem0_nxt, rem1_nxt;

    if (s == 0) begin : g_head
      assign rem0_in = '0;
      assign rem1_in = '0;
      assign nq0_in  = num0_i;
      assign nq1_in  = num1_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = flow_i.vld;
    end else begin : g_body
      assign rem0_in = rem0_r[s-1];
      assign rem1_in = rem1_r[s-1];
      assign nq0_in  = nq0_r[s-1];
      assign nq1_in  = nq1_r[s-1];
      assign den_in  = den_r[s-1];
      assign side_in = side_r[s-1];
      assign vld_in  = vld_r[s-1];
    end

    assign t0  = {rem0_in, nq0_in[NUM_W-1]};
    assign t1  = {rem1_in, nq1_in[NUM_W-1]};
    assign ge0 = t0 >= {1'b0, den_in};
    assign ge1 = t1 >= {1'b0, den_in};
    assign rem0_nxt = ge0 ? DEN_W'(t0 - {1'b0, den_in}) : DEN_W'(t0);
    assign rem1_nxt = ge1 ? DEN_W'(t1 - {1'b0, den_in}) : DEN_W'(t1);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (flow_i.adv) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (flow_i.adv) begin
        rem0_r[s] <= rem0_nxt;
        rem1_r[s] <= rem1_nxt;
        nq0_r[s]  <= {nq0_in[NUM_W-2:0], ge0};
        nq1_r[s]  <= {nq1_in[NUM_W-2:0], ge1};
        den_r[s]  <= den_in;
        side_r[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[NUM_W-1];
  assign quo0_o = nq0_r[NUM_W-1];
  assign quo1_o = nq1_r[NUM_W-1];
  assign side_o = side_r[NUM_W-1];

endmodule

`default_nettype wire

>>> rtl/tvp_sqrt.sv
// Pipelined integer square root, one result bit per stage, truncating.
`default_nettype none

module tvp_sqrt #(
  parameter int IN_W   = 42,
  parameter int SIDE_W = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tvp_pkg::tvp_flow_t           flow_i,
  input  logic [IN_W-1:0]              rad_i,
  input  logic [SIDE_W-1:0]            side_i,
  output logic                         vld_o,
  output logic [(IN_W+1)/2-1:0]        root_o,
  output logic [SIDE_W-1:0]            side_o
);
  import tvp_pkg::*;

  localparam int ROOT_W = (IN_W + 1) / 2;
  localparam int EV_W   = 2 * ROOT_W;

  logic [ROOT_W-1:0] rem_r  [ROOT_W];
  logic [EV_W-1:0]   rad_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [SIDE_W-1:0] side_r [ROOT_W];
  logic [ROOT_W-1:0] vld_r;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [ROOT_W-1:0] rem_in, root_in;
    logic [EV_W-1:0]   rad_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [ROOT_W+1:0] t, trial;
    logic              ge;

    if (s == 0) begin : g_head
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = EV_W'(rad_i);
      assign side_in = side_i;
      assign vld_in  = flow_i.vld;
    end else begin : g_body
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign rad_in  = rad_r[s-1];
      assign side_in = side_r[s-1];
      assign vld_in  = vld_r[s-1];
    end

    assign t     = {rem_in, rad_in[EV_W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (flow_i.adv) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (flow_i.adv) begin
        rem_r[s]  <= ge ? ROOT_W'(t - trial) : ROOT_W'(t);
        root_r[s] <= {root_in[ROOT_W-2:0], ge};
        rad_r[s]  <= {rad_in[EV_W-3:0], 2'b00};
        side_r[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[ROOT_W-1];
  assign root_o = root_r[ROOT_W-1];
  assign side_o = side_r[ROOT_W-1];

endmodule

`default_nettype wire

>>> rtl/trapezoidal_velocity_profile_core.sv
// Top level of the trapezoidal velocity profile core.
//
// One input beat on in_* carries a point of a path segment: start speed, end speed,
// segment length and distance left. One output beat on out_* returns the profile speed
// (out_tdata) and its phase (out_tuser). Top speed and acceleration are written on the
// cfg_* channel, index 0 and 1; cfg_ready is always high.
// Each beat passes through three setup stages, the bit-serial divider pipeline, the peak
// square root, two decision stages, the final square root and the output register.
// Throughput is one beat per cycle. The whole pipeline advances together; it holds
// only when the output register is full and not taken while a result is arriving,
// so a new beat is still accepted while a finished result waits, as long as the stage
// in front of the output is empty.
// Reset clears all stage valid bits and loads top speed and acceleration with 1024.
`default_nettype none

module trapezoidal_velocity_profile_core #(
  parameter int SPEED_BITS = 16,
  parameter int DIST_BITS  = 24,
  parameter int MIN_LENGTH = 10
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             cfg_valid,
  output logic                                             cfg_ready,
  input  logic [tvp_pkg::CFG_IDX_W-1:0]                    cfg_index,
  input  logic [tvp_pkg::CFG_W-1:0]                        cfg_data,
  input  logic                                             in_tvalid,
  output logic                                             in_tready,
  // start_speed, end_speed, segment_length, distance_left
  input  logic [((2*SPEED_BITS+2*DIST_BITS+7)/8)*8-1:0]   in_tdata,
  output logic                                             out_tvalid,
  input  logic                                             out_tready,
  // speed
  output logic [((SPEED_BITS+7)/8)*8-1:0]                  out_tdata,
  // phase
  output logic [1:0]                                       out_tuser
);
  import tvp_pkg::*;

  localparam int SQ_W      = 2 * SPEED_BITS;
  localparam int A2_W      = CFG_W + 1;
  localparam int AL_W      = CFG_W + DIST_BITS;
  localparam int A2X_W     = A2_W + DIST_BITS;
  localparam int PK_SUM_W  = ((SQ_W > AL_W) ? SQ_W : AL_W) + 1;
  localparam int PK_IN_W   = (PK_SUM_W > 64) ? 64 : PK_SUM_W;
  localparam int PK_R_W    = (PK_IN_W + 1) / 2;
  localparam int RAD_SUM_W = ((SQ_W > A2X_W) ? SQ_W : A2X_W) + 1;
  localparam int RAD_IN_W  = (RAD_SUM_W > 64) ? 64 : RAD_SUM_W;
  localparam int RAD_R_W   = (RAD_IN_W + 1) / 2;
  localparam int PK2_W     = 2 * PK_R_W;
  localparam int DP_W      = (SQ_W > PK2_W) ? SQ_W : PK2_W;
  localparam int CMP_W     = ((SQ_W > DIST_BITS) ? SQ_W : DIST_BITS) + 1;
  localparam int OUT_W     = ((SPEED_BITS + 7) / 8) * 8;
  localparam int SIDE1_W   = PK_IN_W + 1 + (A2X_W + 1) + 2 * RAD_IN_W + SPEED_BITS
                             + 2 * DIST_BITS + 2 + SQ_W;
  localparam int SIDE2_W   = 2 * SQ_W + 1 + (A2X_W + 1) + 2 * RAD_IN_W + SPEED_BITS
                             + 2 * DIST_BITS + 2 + SQ_W;
  localparam int SIDE3_W   = 2 + SPEED_BITS;

  // configuration
  logic [CFG_W-1:0] top_speed_r, accel_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_speed_r <= TOP_SPEED_RST;
      accel_r     <= ACCEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TOP_SPEED: top_speed_r <= cfg_data;
        CFG_ACCEL:     accel_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // flow control
  logic      adv, out_free, sq2_vld, out_valid_r;
  tvp_flow_t div_flow, sq1_flow, sq2_flow;

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = !sq2_vld || out_free;
  assign in_tready = adv;

  // stage 1: unpack, clamp, squares
  logic [SPEED_BITS-1:0] f_vs, f_ve;
  logic [DIST_BITS-1:0]  f_len, f_dl, f_dcl, f_x;
  logic [CFG_W-1:0]      a_eff;

  assign f_vs  = in_tdata[SPEED_BITS-1:0];
  assign f_ve  = in_tdata[2*SPEED_BITS-1:SPEED_BITS];
  assign f_len = in_tdata[2*SPEED_BITS+DIST_BITS-1:2*SPEED_BITS];
  assign f_dl  = in_tdata[2*SPEED_BITS+2*DIST_BITS-1:2*SPEED_BITS+DIST_BITS];
  assign f_dcl = (f_dl > f_len) ? f_len - DIST_BITS'(MIN_LENGTH) : f_dl;
  assign f_x   = f_len - f_dcl;
  assign a_eff = (accel_r == '0) ? CFG_W'(1) : accel_r;

  logic                  p1_vld_r, p1_short_r;
  logic [SPEED_BITS-1:0] p1_vs_r, p1_ve_r, p1_vmax_r;
  logic [A2_W-1:0]       p1_a2_r;
  logic [DIST_BITS-1:0]  p1_len_r, p1_x_r, p1_d_r;
  logic [SQ_W-1:0]       p1_sqs_r, p1_sqe_r, p1_sqm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_short_r <= f_len < DIST_BITS'(MIN_LENGTH);
      p1_vs_r    <= f_vs;
      p1_ve_r    <= f_ve;
      p1_vmax_r  <= SPEED_BITS'(top_speed_r);
      p1_a2_r    <= {a_eff, 1'b0};
      p1_len_r   <= f_len;
      p1_x_r     <= f_x;
      p1_d_r     <= f_dcl;
      p1_sqs_r   <= SQ_W'(f_vs) * SQ_W'(f_vs);
      p1_sqe_r   <= SQ_W'(f_ve) * SQ_W'(f_ve);
      p1_sqm_r   <= SQ_W'(SPEED_BITS'(top_speed_r)) * SQ_W'(SPEED_BITS'(top_speed_r));
    end
  end

  // stage 2: differences of squares, distance products
  logic                  p2_vld_r, p2_short_r, p2_gt_r;
  logic [SQ_W-1:0]       p2_dacc_r, p2_ddec_r, p2_dsv_r, p2_half_r, p2_sqs_r, p2_sqe_r;
  logic [AL_W-1:0]       p2_al_r;
  logic [A2X_W-1:0]      p2_a2x_r, p2_a2d_r;
  logic [SPEED_BITS-1:0] p2_vmax_r;
  logic [A2_W-1:0]       p2_a2_r;
  logic [DIST_BITS-1:0]  p2_len_r, p2_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (adv) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_dacc_r  <= (p1_sqm_r > p1_sqs_r) ? p1_sqm_r - p1_sqs_r : p1_sqs_r - p1_sqm_r;
      p2_ddec_r  <= (p1_sqm_r > p1_sqe_r) ? p1_sqm_r - p1_sqe_r : p1_sqe_r - p1_sqm_r;
      p2_dsv_r   <= (p1_sqs_r > p1_sqe_r) ? p1_sqs_r - p1_sqe_r : p1_sqe_r - p1_sqs_r;
      p2_half_r  <= (p1_sqs_r >> 1) + (p1_sqe_r >> 1) + SQ_W'(p1_sqs_r[0] & p1_sqe_r[0]);
      p2_al_r    <= AL_W'(p1_a2_r[A2_W-1:1]) * AL_W'(p1_len_r);
      p2_a2x_r   <= A2X_W'(p1_a2_r) * A2X_W'(p1_x_r);
      p2_a2d_r   <= A2X_W'(p1_a2_r) * A2X_W'(p1_d_r);
      p2_gt_r    <= p1_vs_r > p1_ve_r;
      p2_short_r <= p1_short_r;
      p2_sqs_r   <= p1_sqs_r;
      p2_sqe_r   <= p1_sqe_r;
      p2_vmax_r  <= p1_vmax_r;
      p2_a2_r    <= p1_a2_r;
      p2_len_r   <= p1_len_r;
      p2_x_r     <= p1_x_r;
    end
  end

  // stage 3: saturated radicands, peak case test
  logic [PK_SUM_W-1:0]  pk_sum;
  logic [RAD_SUM_W-1:0] ra_sum, rd_sum;

  assign pk_sum = PK_SUM_W'(p2_half_r) + PK_SUM_W'(p2_al_r);
  assign ra_sum = RAD_SUM_W'(p2_sqs_r) + RAD_SUM_W'(p2_a2x_r);
  assign rd_sum = RAD_SUM_W'(p2_sqe_r) + RAD_SUM_W'(p2_a2d_r);

  logic                  p3_vld_r, p3_short_r, p3_gt_r, p3_case2_r;
  logic [PK_IN_W-1:0]    p3_pk_in_r;
  logic [A2X_W:0]        p3_a2x1_r;
  logic [RAD_IN_W-1:0]   p3_rad_acc_r, p3_rad_dec_r;
  logic [SQ_W-1:0]       p3_dacc_r, p3_ddec_r, p3_sqs_r;
  logic [A2_W-1:0]       p3_a2_r;
  logic [SPEED_BITS-1:0] p3_vmax_r;
  logic [DIST_BITS-1:0]  p3_len_r, p3_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (adv) begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_pk_in_r   <= (|(pk_sum >> PK_IN_W)) ? '1 : PK_IN_W'(pk_sum);
      p3_rad_acc_r <= (|(ra_sum >> RAD_IN_W)) ? '1 : RAD_IN_W'(ra_sum);
      p3_rad_dec_r <= (|(rd_sum >> RAD_IN_W)) ? '1 : RAD_IN_W'(rd_sum);
      p3_case2_r   <= p2_dsv_r < {p2_al_r, 1'b0};
      p3_a2x1_r    <= {1'b0, p2_a2x_r} + (A2X_W+1)'(p2_a2_r);
      p3_dacc_r    <= p2_dacc_r;
      p3_ddec_r    <= p2_ddec_r;
      p3_sqs_r     <= p2_sqs_r;
      p3_a2_r      <= p2_a2_r;
      p3_vmax_r    <= p2_vmax_r;
      p3_len_r     <= p2_len_r;
      p3_x_r       <= p2_x_r;
      p3_short_r   <= p2_short_r;
      p3_gt_r      <= p2_gt_r;
    end
  end

  // acceleration and deceleration distances
  logic                  div_vld;
  logic [SQ_W-1:0]       div_acc, div_dec;
  logic [SIDE1_W-1:0]    side1_in, side1_out;

  assign div_flow = '{adv: adv, vld: p3_vld_r};
  assign side1_in = {p3_pk_in_r, p3_case2_r, p3_a2x1_r, p3_rad_acc_r, p3_rad_dec_r,
                     p3_vmax_r, p3_len_r, p3_x_r, p3_short_r, p3_gt_r, p3_sqs_r};

  tvp_div2 #(
    .NUM_W  (SQ_W),
    .DEN_W  (A2_W),
    .SIDE_W (SIDE1_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .flow_i (div_flow),
    .num0_i (p3_dacc_r),
    .num1_i (p3_ddec_r),
    .den_i  (p3_a2_r),
    .side_i (side1_in),
    .vld_o  (div_vld),
    .quo0_o (div_acc),
    .quo1_o (div_dec),
    .side_o (side1_out)
  );

  logic [PK_IN_W-1:0]   q_pk_in;
  logic [SIDE2_W-1:0]   side2_in, side2_out;
  logic [SIDE2_W-SQ_W*2-1:0] q_rest;

  assign {q_pk_in, q_rest} = side1_out;
  assign side2_in = {div_acc, div_dec, q_rest};
  assign sq1_flow = '{adv: adv, vld: div_vld};

  // triangular peak speed
  logic                sq1_vld;
  logic [PK_R_W-1:0]   peak;

  tvp_sqrt #(
    .IN_W   (PK_IN_W),
    .SIDE_W (SIDE2_W)
  ) u_sqrt_peak (
    .clk    (clk),
    .rst_n  (rst_n),
    .flow_i (sq1_flow),
    .rad_i  (q_pk_in),
    .side_i (side2_in),
    .vld_o  (sq1_vld),
    .root_o (peak),
    .side_o (side2_out)
  );

  logic [SQ_W-1:0]       k_acc, k_dec, k_sqs;
  logic                  k_case2, k_short, k_gt;
  logic [A2X_W:0]        k_a2x1;
  logic [RAD_IN_W-1:0]   k_rad_acc, k_rad_dec;
  logic [SPEED_BITS-1:0] k_vmax;
  logic [DIST_BITS-1:0]  k_len, k_x;

  assign {k_acc, k_dec, k_case2, k_a2x1, k_rad_acc, k_rad_dec, k_vmax, k_len, k_x,
          k_short, k_gt, k_sqs} = side2_out;

  // decision 1: peak square, distance compares
  logic                  d1_vld_r, d1_case1_r, d1_xa_r, d1_xc_r;
  logic                  d1_case2_r, d1_short_r, d1_gt_r;
  logic [PK2_W-1:0]      d1_pk2_r;
  logic [A2X_W:0]        d1_a2x1_r;
  logic [RAD_IN_W-1:0]   d1_rad_acc_r, d1_rad_dec_r;
  logic [SPEED_BITS-1:0] d1_vmax_r;
  logic [SQ_W-1:0]       d1_sqs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r <= 1'b0;
    end else if (adv) begin
      d1_vld_r <= sq1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_pk2_r     <= PK2_W'(peak) * PK2_W'(peak);
      d1_case1_r   <= (CMP_W'(k_acc) + CMP_W'(k_dec)) < CMP_W'(k_len);
      d1_xa_r      <= CMP_W'(k_x) < CMP_W'(k_acc);
      d1_xc_r      <= (CMP_W'(k_x) + CMP_W'(k_dec)) < CMP_W'(k_len);
      d1_case2_r   <= k_case2;
      d1_short_r   <= k_short;
      d1_gt_r      <= k_gt;
      d1_a2x1_r    <= k_a2x1;
      d1_rad_acc_r <= k_rad_acc;
      d1_rad_dec_r <= k_rad_dec;
      d1_vmax_r    <= k_vmax;
      d1_sqs_r     <= k_sqs;
    end
  end

  // decision 2: pick phase and radicand
  logic [DP_W-1:0]     dp;
  logic                pa;
  tvp_phase_t          d2_phase_nxt;
  logic [RAD_IN_W-1:0] d2_rad_nxt;

  assign dp = (DP_W'(d1_sqs_r) > DP_W'(d1_pk2_r)) ? DP_W'(d1_sqs_r) - DP_W'(d1_pk2_r)
                                                  : DP_W'(d1_pk2_r) - DP_W'(d1_sqs_r);
  assign pa = dp >= d1_a2x1_r;

  always_comb begin
    d2_phase_nxt = PH_ACCEL;
    d2_rad_nxt   = d1_rad_acc_r;
    if (d1_short_r) begin
      d2_phase_nxt = PH_SHORT;
    end else if (d1_case1_r) begin
      if (d1_xa_r) begin
        d2_phase_nxt = PH_ACCEL;
      end else if (d1_xc_r) begin
        d2_phase_nxt = PH_CRUISE;
      end else begin
        d2_phase_nxt = PH_DECEL;
        d2_rad_nxt   = d1_rad_dec_r;
      end
    end else if (d1_case2_r) begin
      if (!pa) begin
        d2_phase_nxt = PH_DECEL;
        d2_rad_nxt   = d1_rad_dec_r;
      end
    end else if (d1_gt_r) begin
      d2_phase_nxt = PH_DECEL;
      d2_rad_nxt   = d1_rad_dec_r;
    end
  end

  logic                  d2_vld_r;
  tvp_phase_t            d2_phase_r;
  logic [RAD_IN_W-1:0]   d2_rad_r;
  logic [SPEED_BITS-1:0] d2_vmax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_vld_r <= 1'b0;
    end else if (adv) begin
      d2_vld_r <= d1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_phase_r <= d2_phase_nxt;
      d2_rad_r   <= d2_rad_nxt;
      d2_vmax_r  <= d1_vmax_r;
    end
  end

  // profile speed root
  logic [SIDE3_W-1:0]    side3_in, side3_out;
  logic [RAD_R_W-1:0]    root;
  logic [1:0]            r_phase_bits;
  logic [SPEED_BITS-1:0] r_vmax;
  tvp_phase_t            r_phase;

  assign side3_in = {d2_phase_r, d2_vmax_r};
  assign sq2_flow = '{adv: adv, vld: d2_vld_r};

  tvp_sqrt #(
    .IN_W   (RAD_IN_W),
    .SIDE_W (SIDE3_W)
  ) u_sqrt_speed (
    .clk    (clk),
    .rst_n  (rst_n),
    .flow_i (sq2_flow),
    .rad_i  (d2_rad_r),
    .side_i (side3_in),
    .vld_o  (sq2_vld),
    .root_o (root),
    .side_o (side3_out)
  );

  assign {r_phase_bits, r_vmax} = side3_out;
  assign r_phase = tvp_phase_t'(r_phase_bits);

  // output register
  logic [SPEED_BITS-1:0] speed_nxt, out_speed_r;
  tvp_phase_t            out_phase_r;

  always_comb begin
    case (r_phase)
      PH_SHORT:  speed_nxt = '0;
      PH_CRUISE: speed_nxt = r_vmax;
      default:   speed_nxt = (|(root >> SPEED_BITS)) ? '1 : SPEED_BITS'(root);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= sq2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_speed_r <= speed_nxt;
      out_phase_r <= r_phase;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_speed_r);
  assign out_tuser  = out_phase_r;

  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && sq2_vld) |-> !in_tready)
    else $error("input accepted while a result would be dropped");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_phase_r == PH_SHORT) |-> (out_speed_r == '0))
    else $error("short segment with nonzero speed");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> p1_vld_r)
    else $error("accepted beat did not enter the pipeline");

  a_cfg_reset: assert property (@(posedge clk)
    !rst_n |=> (top_speed_r == TOP_SPEED_RST && accel_r == ACCEL_RST))
    else $error("configuration not restored by reset");

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the trapezoidal velocity profile core.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tvp_pkg::*;

  localparam int MIN_LEN   = 10;
  localparam int LATENCY   = 80;
  localparam int STALL_MAX = 4000;

  typedef struct packed {
    logic [15:0] speed;
    tvp_phase_t  phase;
  } profile_pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [79:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0] out_tuser;

  longint unsigned top_speed_q = 1024;
  longint unsigned accel_q = 1024;
  profile_pt_t pending_pts[$];
  int errors = 0;
  int idle_cycles = 0;
  bit rx_hold = 1'b0;

  always #10 clk = ~clk;

  trapezoidal_velocity_profile_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  function automatic longint unsigned sat_sum(longint unsigned x, longint unsigned y);
    longint unsigned s;
    s = x + y;
    return (s < x) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned ramp_dist(longint unsigned v1, longint unsigned v2,
                                                longint unsigned a);
    longint unsigned s1, s2;
    s1 = v1 * v1;
    s2 = v2 * v2;
    return ((s1 > s2) ? (s1 - s2) : (s2 - s1)) / (2 * a);
  endfunction

  function automatic longint unsigned ramp_speed(longint unsigned v, longint unsigned a,
                                                 longint unsigned x);
    return int_sqrt(sat_sum(v * v, 2 * a * x));
  endfunction

  function automatic profile_pt_t profile_at(longint unsigned vs, longint unsigned ve,
                                             longint unsigned l, longint unsigned d);
    profile_pt_t p;
    longint unsigned a, vmax, x, acc, dec, spd, sq, eq, half, peak;
    a = (accel_q == 0) ? 1 : accel_q;
    vmax = top_speed_q;
    if (l < MIN_LEN) begin
      p.speed = '0;
      p.phase = PH_SHORT;
      return p;
    end
    if (d > l) d = l - MIN_LEN;
    x = l - d;
    acc = ramp_dist(vmax, vs, a);
    dec = ramp_dist(vmax, ve, a);
    if (sat_sum(acc, dec) < l) begin
      if (x < acc) begin
        spd = ramp_speed(vs, a, x);
        p.phase = PH_ACCEL;
      end else if (x < l - dec) begin
        spd = vmax;
        p.phase = PH_CRUISE;
      end else begin
        spd = ramp_speed(ve, a, d);
        p.phase = PH_DECEL;
      end
    end else if (ramp_dist(vs, ve, a) < l) begin
      sq = vs * vs;
      eq = ve * ve;
      half = (sq >> 1) + (eq >> 1) + (sq & eq & 1);
      peak = int_sqrt(sat_sum(half, a * l));
      if (x < ramp_dist(vs, peak, a)) begin
        spd = ramp_speed(vs, a, x);
        p.phase = PH_ACCEL;
      end else begin
        spd = ramp_speed(ve, a, d);
        p.phase = PH_DECEL;
      end
    end else if (vs > ve) begin
      spd = ramp_speed(ve, a, d);
      p.phase = PH_DECEL;
    end else begin
      spd = ramp_speed(vs, a, x);
      p.phase = PH_ACCEL;
    end
    p.speed = (spd > 65535) ? 16'hFFFF : spd[15:0];
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (rx_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (pick_gap() == 0);
    end
  end

  always @(posedge clk) begin
    profile_pt_t want;
    if (out_tvalid && out_tready) begin
      if (pending_pts.size() == 0) begin
        $error("unexpected result speed=%0d phase=%0d", out_tdata, out_tuser);
        errors++;
      end else begin
        want = pending_pts.pop_front();
        if (out_tdata !== want.speed) begin
          $error("speed: expected %0d, actual %0d", want.speed, out_tdata);
          errors++;
        end
        if (out_tuser !== want.phase) begin
          $error("phase: expected %0d, actual %0d", want.phase, out_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_point(logic [15:0] vs, logic [15:0] ve, logic [23:0] l, logic [23:0] d,
                            int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {d, l, ve, vs};
    do @(posedge clk); while (!in_tready);
    pending_pts = {pending_pts, profile_at(64'(vs), 64'(ve), 64'(l), 64'(d))};
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TOP_SPEED) top_speed_q = 64'(val);
    else accel_q = 64'(val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(int gap);
    logic [15:0] vs, ve;
    logic [23:0] l, d;
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: l = 24'($urandom_range(0, 30));
      1, 2: l = 24'($urandom);
      default: l = 24'($urandom_range(0, 4095));
    endcase
    vs = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                     : 16'($urandom_range(0, 32'(2 * top_speed_q + 1)));
    ve = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                     : 16'($urandom_range(0, 32'(2 * top_speed_q + 1)));
    d = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 32'(l)));
    send_point(vs, ve, l, d, gap);
  endtask

  task automatic test_directed();
    send_point(16'd0, 16'd0, 24'd0, 24'd0, 0);
    send_point(16'd100, 16'd100, 24'd9, 24'd5, 0);
    send_point(16'd0, 16'd0, 24'd10, 24'd10, 0);
    send_point(16'd0, 16'd0, 24'd5000, 24'd6000, 0);
    send_point(16'd0, 16'd0, 24'd5000, 24'd4990, 1);
    send_point(16'd0, 16'd0, 24'd5000, 24'd2500, 0);
    send_point(16'd0, 16'd0, 24'd5000, 24'd10, 0);
    send_point(16'd0, 16'd0, 24'd5000, 24'd0, 2);
    send_point(16'd0, 16'd0, 24'd1024, 24'd512, 0);
    send_point(16'd0, 16'd0, 24'd1024, 24'd0, 0);
    send_point(16'd0, 16'd0, 24'd1024, 24'd1024, 0);
    send_point(16'd0, 16'd0, 24'd1024, 24'd1536, 0);
    send_point(16'd0, 16'd0, 24'd1024, 24'd1535, 0);
    send_point(16'd0, 16'd0, 24'd1024, 24'd511, 0);
    send_point(16'd0, 16'd2000, 24'd200, 24'd100, 0);
    send_point(16'd2000, 16'd0, 24'd200, 24'd100, 0);
    send_point(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 0);
    send_point(16'hFFFF, 16'd0, 24'hFFFFFF, 24'd0, 0);
    send_point(16'd0, 16'hFFFF, 24'hFFFFFF, 24'h800000, 0);
    send_point(16'd1024, 16'd1024, 24'd2048, 24'd1024, 0);
    send_point(16'd5000, 16'd5000, 24'd100000, 24'd50000, 0);
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_TOP_SPEED, 16'd0);
    write_reg(CFG_ACCEL, 16'd0);
    repeat (20) send_random(pick_gap());
    write_reg(CFG_TOP_SPEED, 16'hFFFF);
    write_reg(CFG_ACCEL, 16'hFFFF);
    repeat (20) send_random(pick_gap());
    write_reg(CFG_ACCEL, 16'd1);
    repeat (20) send_random(pick_gap());
  endtask

  task automatic test_random();
    for (int k = 0; k < 5; k++) begin
      write_reg(CFG_TOP_SPEED,
                16'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 4096) : $urandom));
      write_reg(CFG_ACCEL,
                16'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 4096) : $urandom));
      repeat (100) send_random(pick_gap());
    end
  endtask

  task automatic test_backpressure();
    write_reg(CFG_TOP_SPEED, 16'd1024);
    write_reg(CFG_ACCEL, 16'd1024);
    fork
      begin
        rx_hold = 1'b1;
        repeat (300) @(negedge clk);
        rx_hold = 1'b0;
      end
      repeat (150) send_random(0);
    join
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_extremes();
    test_random();
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/tvp_pkg.sv
rtl/tvp_div2.sv
rtl/tvp_sqrt.sv
rtl/trapezoidal_velocity_profile_core.sv
test/tb_top.sv
